// ----- sv/transfer_time_calculator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Transfer time calculator assertion macros
// Shared helpers for the concurrent checks in the transfer time calculator.
// ----------------------------------------------------------------------------
`ifndef TRANSFER_TIME_CALCULATOR_CORE_DEFINES_SVH
`define TRANSFER_TIME_CALCULATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TTC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication with a fixed number of cycles between cause and effect.
`define TTC_ASSERT_AFTER(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

// ----- sv/ttc_pkg.sv -----
// ----------------------------------------------------------------------------
// Transfer time calculator package
// Types, constants and register codes shared by the calculator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

   // Scale factor from seconds to nanoseconds.
   localparam logic [31:0] NS_PER_SECOND = 32'd1000000000;
   localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
   // Largest whole-second count whose product with the scale still fits.
   localparam logic [63:0] MAX_WHOLE     = ALL_ONES / 64'(NS_PER_SECOND);

   // Pipeline geometry.
   localparam int DIV_STAGES    = 64;
   localparam int CEIL_BITS     = 32;
   localparam int CEIL_STAGES   = 2 * CEIL_BITS;
   localparam int SECS_STAGES   = 2;
   localparam int FINISH_STAGES = 3;
   localparam int LATENCY       = 1 + DIV_STAGES + SECS_STAGES + CEIL_STAGES + FINISH_STAGES;

   // Register map.
   localparam int CSR_INDEX_LSB  = 3;
   localparam int CSR_ADDR_WIDTH = CSR_INDEX_LSB + 2;

   typedef enum logic [1:0] {
      CSR_FETCH_BANDWIDTH = 2'd0,
      CSR_EVICT_BANDWIDTH = 2'd1,
      CSR_FETCH_LATENCY   = 2'd2,
      CSR_EVICT_LATENCY   = 2'd3
   } csr_index_type;

   localparam logic DIR_EVICT = 1'b1;

   typedef struct packed {
      logic [63:0] size_bytes;
      logic        direction;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] runtime_ns;
      logic        saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0] fetch_bandwidth;
      logic [63:0] evict_bandwidth;
      logic [63:0] fetch_latency;
      logic [63:0] evict_latency;
   } csr_regs_type;

   // One stage of the restoring divider: quo starts as the dividend and fills
   // with quotient bits from the bottom.
   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] bw;
      logic [63:0] lat;
   } div_stage_type;

   // One stage of the fractional ceiling multiply-divide.
   typedef struct packed {
      logic [63:0] r;
      logic [31:0] q;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] secs;
      logic [63:0] lat;
      logic        sat;
   } ceil_stage_type;

endpackage

`default_nettype wire

// ----- sv/ttc_csr.sv -----
// ----------------------------------------------------------------------------
// Transfer time calculator register file
// Bandwidth and latency registers for both directions behind an APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttc_csr
   import ttc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [63:0]               pwdata,
   output      logic [63:0]               prdata,
   output      logic                      pready,
   output      csr_regs_type              csr_regs
);

   csr_regs_type  csr_ff;
   csr_regs_type  csr_in;
   csr_index_type index;
   logic          write_en;

   assign index    = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign csr_regs = csr_ff;

   // Write decode.
   always_comb begin
      csr_in = csr_ff;
      if (write_en) begin
         unique case (index)
            CSR_FETCH_BANDWIDTH: csr_in.fetch_bandwidth = pwdata;
            CSR_EVICT_BANDWIDTH: csr_in.evict_bandwidth = pwdata;
            CSR_FETCH_LATENCY:   csr_in.fetch_latency   = pwdata;
            CSR_EVICT_LATENCY:   csr_in.evict_latency   = pwdata;
            default:             csr_in = csr_ff;
         endcase
      end
   end

   // Read decode.
   always_comb begin
      unique case (index)
         CSR_FETCH_BANDWIDTH: prdata = csr_ff.fetch_bandwidth;
         CSR_EVICT_BANDWIDTH: prdata = csr_ff.evict_bandwidth;
         CSR_FETCH_LATENCY:   prdata = csr_ff.fetch_latency;
         CSR_EVICT_LATENCY:   prdata = csr_ff.evict_latency;
         default:             prdata = '0;
      endcase
   end

   // Register bank; bandwidths come out of reset at one byte per second.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.fetch_bandwidth <= 64'd1;
         csr_ff.evict_bandwidth <= 64'd1;
         csr_ff.fetch_latency   <= '0;
         csr_ff.evict_latency   <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/ttc_divider.sv -----
// ----------------------------------------------------------------------------
// Transfer time calculator divider
// Entry stage plus a 64-stage restoring divider giving size / bandwidth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "transfer_time_calculator_core_defines.svh"

module ttc_divider
   import ttc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire req_payload_type req_payload,
   input  wire csr_regs_type    csr_regs,
   output      logic            div_valid,
   output      div_stage_type   div_stage
);

   logic [DIV_STAGES:0] valid_ff;
   div_stage_type       stage_ff [DIV_STAGES+1];
   div_stage_type       entry_in;

   // Entry: pick the direction's bandwidth and latency with the request.
   always_comb begin
      entry_in.rem = '0;
      entry_in.quo = req_payload.size_bytes;
      if (req_payload.direction == DIR_EVICT) begin
         entry_in.bw  = csr_regs.evict_bandwidth;
         entry_in.lat = csr_regs.evict_latency;
      end else begin
         entry_in.bw  = csr_regs.fetch_bandwidth;
         entry_in.lat = csr_regs.fetch_latency;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= entry_in;
   end

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DIV_STAGES-1:0], req_valid};
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      logic [64:0]   trial;
      logic [64:0]   diff;
      div_stage_type step_in;

      always_comb begin
         trial   = {stage_ff[k].rem, stage_ff[k].quo[63]};
         diff    = trial - {1'b0, stage_ff[k].bw};
         step_in = stage_ff[k];
         if (trial >= {1'b0, stage_ff[k].bw}) begin
            step_in.rem = diff[63:0];
            step_in.quo = {stage_ff[k].quo[62:0], 1'b1};
         end else begin
            step_in.rem = trial[63:0];
            step_in.quo = {stage_ff[k].quo[62:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[k+1] <= step_in;
      end
   end

   assign div_valid = valid_ff[DIV_STAGES];
   assign div_stage = stage_ff[DIV_STAGES];

   // A finished division leaves a remainder below a non-zero divisor.
   `TTC_ASSERT_IMP(a_div_rem_below_bw, clock, reset, div_valid && (div_stage.bw != '0), div_stage.rem < div_stage.bw, "divider remainder not below bandwidth")

endmodule

`default_nettype wire

// ----- sv/ttc_secs.sv -----
// ----------------------------------------------------------------------------
// Transfer time calculator seconds scaler
// Two-stage multiply of whole seconds by the nanosecond scale, with overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttc_secs
   import ttc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           div_valid,
   input  wire div_stage_type  div_stage,
   output      logic           ceil_valid,
   output      ceil_stage_type ceil_stage
);

   logic           valid_a_ff;
   logic [63:0]    prod_lo_ff;
   logic [63:0]    prod_hi_ff;
   logic           sat_a_ff;
   logic [63:0]    rem_a_ff;
   logic [63:0]    bw_a_ff;
   logic [63:0]    lat_a_ff;
   logic [63:0]    prod_lo_in;
   logic [63:0]    prod_hi_in;
   logic           valid_b_ff;
   ceil_stage_type out_ff;
   ceil_stage_type out_in;

   // First stage: split 32-bit partial products and the saturation checks.
   assign prod_lo_in = {32'b0, div_stage.quo[31:0]} * {32'b0, NS_PER_SECOND};
   assign prod_hi_in = {32'b0, div_stage.quo[63:32]} * {32'b0, NS_PER_SECOND};

   always_ff @(posedge clock) begin
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      sat_a_ff   <= (div_stage.bw == '0) || (div_stage.quo > MAX_WHOLE);
      rem_a_ff   <= div_stage.rem;
      bw_a_ff    <= div_stage.bw;
      lat_a_ff   <= div_stage.lat;
   end

   // Second stage: combine the partial products and seed the fraction unit.
   always_comb begin
      out_in.r    = '0;
      out_in.q    = '0;
      out_in.num  = rem_a_ff;
      out_in.den  = bw_a_ff;
      out_in.secs = prod_lo_ff + {prod_hi_ff[31:0], 32'b0};
      out_in.lat  = lat_a_ff;
      out_in.sat  = sat_a_ff;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= div_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   assign ceil_valid = valid_b_ff;
   assign ceil_stage = out_ff;

endmodule

`default_nettype wire

// ----- sv/ttc_ceil.sv -----
// ----------------------------------------------------------------------------
// Transfer time calculator fraction unit
// Floor and leftover of rem * scale / bandwidth without overflow, two stages per bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "transfer_time_calculator_core_defines.svh"

module ttc_ceil
   import ttc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           ceil_valid,
   input  wire ceil_stage_type ceil_stage,
   output      logic           frac_valid,
   output      ceil_stage_type frac_stage
);

   logic [CEIL_STAGES-1:0] valid_ff;
   ceil_stage_type         stage_ff [CEIL_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[CEIL_STAGES-2:0], ceil_valid};
      end
   end

   // Each scale bit, most significant first, takes a doubling stage and then
   // an add stage, which only does work where the scale bit is set. The running
   // remainder stays below the bandwidth, so nothing overflows.
   for (genvar j = 0; j < CEIL_STAGES; j++) begin : g_step
      localparam int BitPos = CEIL_BITS - 1 - (j / 2);
      ceil_stage_type prev;
      ceil_stage_type step_in;

      if (j == 0) begin : g_first
         assign prev = ceil_stage;
      end else begin : g_next
         assign prev = stage_ff[j-1];
      end

      if ((j % 2) == 0) begin : g_double
         logic [63:0] gap;
         always_comb begin
            gap     = prev.den - prev.r;
            step_in = prev;
            if (prev.r >= gap) begin
               step_in.r = prev.r - gap;
               step_in.q = {prev.q[30:0], 1'b1};
            end else begin
               step_in.r = {prev.r[62:0], 1'b0};
               step_in.q = {prev.q[30:0], 1'b0};
            end
         end
      end else if (NS_PER_SECOND[BitPos]) begin : g_add
         logic [63:0] gap;
         always_comb begin
            gap     = prev.den - prev.num;
            step_in = prev;
            if (prev.r >= gap) begin
               step_in.r = prev.r - gap;
               step_in.q = prev.q + 32'd1;
            end else begin
               step_in.r = prev.r + prev.num;
            end
         end
      end else begin : g_hold
         assign step_in = prev;
      end

      always_ff @(posedge clock) begin
         stage_ff[j] <= step_in;
      end
   end

   assign frac_valid = valid_ff[CEIL_STAGES-1];
   assign frac_stage = stage_ff[CEIL_STAGES-1];

   // With a valid bandwidth the floor quotient is below the scale and the
   // leftover below the bandwidth.
   `TTC_ASSERT_IMP(a_ceil_bounds, clock, reset, frac_valid && (frac_stage.den != '0), (frac_stage.r < frac_stage.den) && (frac_stage.q < NS_PER_SECOND), "fraction unit out of range")

endmodule

`default_nettype wire

// ----- sv/ttc_finish.sv -----
// ----------------------------------------------------------------------------
// Transfer time calculator finishing stages
// Rounds the fraction up, adds seconds and latency, saturates on overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "transfer_time_calculator_core_defines.svh"

module ttc_finish
   import ttc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            frac_valid,
   input  wire ceil_stage_type  frac_stage,
   output      logic            rsp_valid,
   output      rsp_payload_type rsp_payload
);

   logic            valid_a_ff;
   logic [32:0]     part_ff;
   logic [63:0]     secs_a_ff;
   logic [63:0]     lat_a_ff;
   logic            sat_a_ff;
   logic            valid_b_ff;
   logic [64:0]     sum_in;
   logic [63:0]     sum_ff;
   logic [63:0]     lat_b_ff;
   logic            sat_b_ff;
   logic [64:0]     total_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   // Round up when anything is left of the remainder.
   always_ff @(posedge clock) begin
      part_ff   <= {1'b0, frac_stage.q} + {32'b0, (frac_stage.r != '0)};
      secs_a_ff <= frac_stage.secs;
      lat_a_ff  <= frac_stage.lat;
      sat_a_ff  <= frac_stage.sat;
   end

   // Seconds plus fraction; a carry out saturates.
   assign sum_in = {1'b0, secs_a_ff} + {32'b0, part_ff};

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in[63:0];
      lat_b_ff <= lat_a_ff;
      sat_b_ff <= sat_a_ff || sum_in[64];
   end

   // Add the latency and form the response.
   assign total_in = {1'b0, sum_ff} + {1'b0, lat_b_ff};

   always_comb begin
      if (sat_b_ff || total_in[64]) begin
         rsp_in.runtime_ns = ALL_ONES;
         rsp_in.saturated  = 1'b1;
      end else begin
         rsp_in.runtime_ns = total_in[63:0];
         rsp_in.saturated  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= frac_valid;
         valid_b_ff   <= valid_a_ff;
         rsp_valid_ff <= valid_b_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A flagged response always reads as all ones.
   `TTC_ASSERT_IMP(a_sat_all_ones, clock, reset, rsp_valid && rsp_payload.saturated, rsp_payload.runtime_ns == ALL_ONES, "saturated response not all ones")

endmodule

`default_nettype wire

// ----- sv/transfer_time_calculator_core.sv -----
// ----------------------------------------------------------------------------
// Transfer time calculator
// Nanoseconds to move a transfer: ceil(size * 1e9 / bandwidth) + latency.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle whenever busy is low, and busy is
// high only during reset. Each request gives exactly one response, strobed by
// rsp_valid for a single cycle, in request order; the receiver cannot hold
// responses off, so it must take every strobe. The pipeline is made of the
// 64-stage restoring divider (one quotient bit per stage) and the 64-stage
// fraction unit (two stages per bit of the 32-bit nanosecond scale), plus one
// entry, two multiply and three finishing stages. Bandwidth and latency are
// sampled when a request is taken. A zero bandwidth or any overflow returns
// all ones with saturated set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "transfer_time_calculator_core_defines.svh"

module transfer_time_calculator_core
   import ttc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Request channel
   input  wire logic                      start,
   output      logic                      busy,
   input  wire req_payload_type           req_payload,
   // Response channel
   output      logic                      rsp_valid,
   output      rsp_payload_type           rsp_payload,
   // Register port
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [63:0]               pwdata,
   output      logic [63:0]               prdata,
   output      logic                      pready
);

   csr_regs_type   csr_regs;
   logic           req_accept;
   logic           div_valid;
   div_stage_type  div_stage;
   logic           ceil_valid;
   ceil_stage_type ceil_stage;
   logic           frac_valid;
   ceil_stage_type frac_stage;

   // The pipeline never stalls, so requests are refused only in reset.
   assign busy       = reset;
   assign req_accept = start && !busy;

   ttc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .csr_regs (csr_regs)
   );

   ttc_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_accept),
      .req_payload (req_payload),
      .csr_regs    (csr_regs),
      .div_valid   (div_valid),
      .div_stage   (div_stage)
   );

   ttc_secs u_secs (
      .clock      (clock),
      .reset      (reset),
      .div_valid  (div_valid),
      .div_stage  (div_stage),
      .ceil_valid (ceil_valid),
      .ceil_stage (ceil_stage)
   );

   ttc_ceil u_ceil (
      .clock      (clock),
      .reset      (reset),
      .ceil_valid (ceil_valid),
      .ceil_stage (ceil_stage),
      .frac_valid (frac_valid),
      .frac_stage (frac_stage)
   );

   ttc_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .frac_valid  (frac_valid),
      .frac_stage  (frac_stage),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // Every request comes back after the fixed latency, and nothing else does.
   `TTC_ASSERT_AFTER(a_req_gives_rsp, clock, reset, req_accept, LATENCY, rsp_valid, "request lost in the pipeline")
   `TTC_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_valid, $past(req_accept, LATENCY), "response without a request")

endmodule

`default_nettype wire
